// File: rtl/tspg_pkg.sv
// shared types and constants for the patch grid target size block
// no dependencies; used by the divider, square root and top level files
`default_nettype none

package tspg_pkg;

   // register indexes on the csr port
   localparam logic [1:0] REG_GRID_FACTOR = 2'd0;
   localparam logic [1:0] REG_MIN_AREA    = 2'd1;
   localparam logic [1:0] REG_MAX_AREA    = 2'd2;

   localparam int GRID_W = 11;
   localparam int AREA_W = 28;

   localparam logic [GRID_W-1:0] GRID_FACTOR_RESET = 11'd28;
   localparam logic [AREA_W-1:0] MIN_AREA_RESET    = 28'd3136;
   localparam logic [AREA_W-1:0] MAX_AREA_RESET    = 28'd1003520;

   // result codes
   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_ASPECT = 2'd1;
   localparam logic [1:0] ERR_RANGE  = 2'd2;

   localparam logic [7:0]  ASPECT_LIMIT = 8'd200;
   localparam logic [29:0] MAX_SIDE     = 30'd16384;

   typedef struct packed {
      logic en;
      logic valid;
   } pipe_ctl_type;

endpackage

`default_nettype wire

// File: rtl/tspg_div.sv
// pipelined restoring divider, one quotient bit per stage, with side payload
// depends on tspg_pkg for the pipeline control struct
`default_nettype none

module tspg_div #(
   parameter int NW = 26,
   parameter int DW = 15,
   parameter int SW = 1
) (
   input  wire                       clock,
   input  wire                       reset,
   input  tspg_pkg::pipe_ctl_type    in_ctl,
   input  wire  [NW-1:0]             in_num,
   input  wire  [DW-1:0]             in_den,
   input  wire  [SW-1:0]             in_side,
   output logic                      out_valid,
   output logic [NW-1:0]             out_quo,
   output logic [DW-1:0]             out_rem,
   output logic [SW-1:0]             out_side
);

   logic [NW-1:0]                valid_ff;
   logic [NW-1:0][NW-1:0]        num_ff;
   logic [NW-1:0][NW-1:0]        quo_ff;
   logic [NW-1:0][DW-1:0]        rem_ff;
   logic [NW-1:0][DW-1:0]        den_ff;
   logic [NW-1:0][SW-1:0]        side_ff;

   for (genvar k = 0; k < NW; k++) begin : g_stage
      logic          v_cur;
      logic [NW-1:0] num_cur;
      logic [NW-1:0] quo_cur;
      logic [DW-1:0] rem_cur;
      logic [DW-1:0] den_cur;
      logic [SW-1:0] side_cur;
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          take;
      logic [DW-1:0] rem_in;
      logic [NW-1:0] quo_in;

      if (k == 0) begin : g_first
         assign v_cur    = in_ctl.valid;
         assign num_cur  = in_num;
         assign quo_cur  = '0;
         assign rem_cur  = '0;
         assign den_cur  = in_den;
         assign side_cur = in_side;
      end else begin : g_next
         assign v_cur    = valid_ff[k-1];
         assign num_cur  = num_ff[k-1];
         assign quo_cur  = quo_ff[k-1];
         assign rem_cur  = rem_ff[k-1];
         assign den_cur  = den_ff[k-1];
         assign side_cur = side_ff[k-1];
      end

      assign trial  = {rem_cur, num_cur[NW-1]};
      assign diff   = trial - {1'b0, den_cur};
      assign take   = (trial >= {1'b0, den_cur});
      assign rem_in = take ? diff[DW-1:0] : trial[DW-1:0];
      assign quo_in = {quo_cur[NW-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (in_ctl.en) begin
            valid_ff[k] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (in_ctl.en) begin
            num_ff[k]  <= num_cur << 1;
            quo_ff[k]  <= quo_in;
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= den_cur;
            side_ff[k] <= side_cur;
         end
      end
   end

   assign out_valid = valid_ff[NW-1];
   assign out_quo   = quo_ff[NW-1];
   assign out_rem   = rem_ff[NW-1];
   assign out_side  = side_ff[NW-1];

endmodule

`default_nettype wire

// File: rtl/tspg_sqrt.sv
// pipelined integer square root, one root bit per stage, with side payload
// depends on tspg_pkg for the pipeline control struct
`default_nettype none

module tspg_sqrt #(
   parameter int NW = 36,
   parameter int SW = 1
) (
   input  wire                       clock,
   input  wire                       reset,
   input  tspg_pkg::pipe_ctl_type    in_ctl,
   input  wire  [NW-1:0]             in_rad,
   input  wire  [SW-1:0]             in_side,
   output logic                      out_valid,
   output logic [NW/2-1:0]           out_root,
   output logic                      out_inexact,
   output logic [SW-1:0]             out_side
);

   localparam int RW = NW / 2;

   logic [RW-1:0]             valid_ff;
   logic [RW-1:0][NW-1:0]     rad_ff;
   logic [RW-1:0][RW-1:0]     root_ff;
   logic [RW-1:0][RW+1:0]     rem_ff;
   logic [RW-1:0][SW-1:0]     side_ff;

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic          v_cur;
      logic [NW-1:0] rad_cur;
      logic [RW-1:0] root_cur;
      logic [RW+1:0] rem_cur;
      logic [SW-1:0] side_cur;
      logic [RW+3:0] pre;
      logic [RW+3:0] trial;
      logic [RW+3:0] diff;
      logic          take;
      logic [RW+1:0] rem_in;
      logic [RW-1:0] root_in;

      if (k == 0) begin : g_first
         assign v_cur    = in_ctl.valid;
         assign rad_cur  = in_rad;
         assign root_cur = '0;
         assign rem_cur  = '0;
         assign side_cur = in_side;
      end else begin : g_next
         assign v_cur    = valid_ff[k-1];
         assign rad_cur  = rad_ff[k-1];
         assign root_cur = root_ff[k-1];
         assign rem_cur  = rem_ff[k-1];
         assign side_cur = side_ff[k-1];
      end

      assign pre     = {rem_cur, rad_cur[NW-1:NW-2]};
      assign trial   = {2'b00, root_cur, 2'b01};
      assign diff    = pre - trial;
      assign take    = (pre >= trial);
      assign rem_in  = take ? diff[RW+1:0] : pre[RW+1:0];
      assign root_in = {root_cur[RW-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (in_ctl.en) begin
            valid_ff[k] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (in_ctl.en) begin
            rad_ff[k]  <= rad_cur << 2;
            root_ff[k] <= root_in;
            rem_ff[k]  <= rem_in;
            side_ff[k] <= side_cur;
         end
      end
   end

   assign out_valid   = valid_ff[RW-1];
   assign out_root    = root_ff[RW-1];
   assign out_inexact = |rem_ff[RW-1];
   assign out_side    = side_ff[RW-1];

endmodule

`default_nettype wire

// File: rtl/target_size_for_patch_grid_top.sv
// patch grid target size: pipelined from an accepted request to rsp_tvalid
// throughput one transaction per cycle; the whole pipeline holds while a result waits
// depth is set by the bit-serial divider chain (26+26+19+47 stages) and 18-stage square root
// synchronous reset clears all valid bits and loads the register defaults
// depends on tspg_pkg, tspg_div and tspg_sqrt
`default_nettype none

module target_size_for_patch_grid_top (
   input  wire         clock,
   input  wire         reset,
   // req_tdata: in_height [14:0], in_width [29:15], zero fill [31:30]
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,
   // rsp_tdata: out_height [15:0], out_width [31:16]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,
   // rsp_tuser: error_code [1:0]
   output logic [1:0]  rsp_tuser,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [3:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [10:0] grid_factor_ff;
   logic [27:0] min_area_ff;
   logic [27:0] max_area_ff;
   logic [10:0] fe_ff, fe_in;
   logic [21:0] ff_ff, ff_in;
   logic        adv;
   logic        cfg_wr;
   tspg_pkg::pipe_ctl_type ctl0, ctl2, ctl4, ctl9, ctl10;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_factor_ff <= tspg_pkg::GRID_FACTOR_RESET;
         min_area_ff    <= tspg_pkg::MIN_AREA_RESET;
         max_area_ff    <= tspg_pkg::MAX_AREA_RESET;
      end else if (cfg_wr) begin
         case (csr_paddr[3:2])
            tspg_pkg::REG_GRID_FACTOR: grid_factor_ff <= csr_pwdata[10:0];
            tspg_pkg::REG_MIN_AREA:    min_area_ff    <= csr_pwdata[27:0];
            tspg_pkg::REG_MAX_AREA:    max_area_ff    <= csr_pwdata[27:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         tspg_pkg::REG_GRID_FACTOR: csr_prdata = {21'd0, grid_factor_ff};
         tspg_pkg::REG_MIN_AREA:    csr_prdata = {4'd0, min_area_ff};
         tspg_pkg::REG_MAX_AREA:    csr_prdata = {4'd0, max_area_ff};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   // effective factor and its square
   assign fe_in = (grid_factor_ff == 11'd0) ? 11'd1 : grid_factor_ff;
   assign ff_in = 22'(fe_in * fe_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         fe_ff <= tspg_pkg::GRID_FACTOR_RESET;
         ff_ff <= 22'(tspg_pkg::GRID_FACTOR_RESET * tspg_pkg::GRID_FACTOR_RESET);
      end else begin
         fe_ff <= fe_in;
         ff_ff <= ff_in;
      end
   end

   logic        out_valid_ff;
   assign adv        = !out_valid_ff || rsp_tready;
   assign req_tready = adv;

   // stage 0: raise of short height
   logic        s0_valid_ff;
   logic [14:0] s0_h_ff, s0_w_ff;
   logic [25:0] s0_wf_ff;
   logic        s0_z_ff, s0_r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_h_ff  <= req_tdata[14:0];
         s0_w_ff  <= req_tdata[29:15];
         s0_wf_ff <= 26'(req_tdata[29:15] * fe_in);
         s0_z_ff  <= (req_tdata[14:0] == 15'd0) || (req_tdata[29:15] == 15'd0);
         s0_r_ff  <= ({4'd0, fe_in} > req_tdata[14:0]);
      end
   end

   assign ctl0.en    = adv;
   assign ctl0.valid = s0_valid_ff;

   logic        d1_valid;
   logic [25:0] d1_quo;
   logic [14:0] d1_rem;
   logic [31:0] d1_side;

   tspg_div #(.NW(26), .DW(15), .SW(32)) u_div1 (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (ctl0),
      .in_num    (s0_wf_ff),
      .in_den    (s0_h_ff),
      .in_side   ({s0_h_ff, s0_w_ff, s0_z_ff, s0_r_ff}),
      .out_valid (d1_valid),
      .out_quo   (d1_quo),
      .out_rem   (d1_rem),
      .out_side  (d1_side)
   );

   // stage 1: rounded width after height raise
   logic        s1_valid_ff;
   logic [14:0] s1_h_ff, s1_h_in;
   logic [25:0] s1_w_ff, s1_w_in;
   logic        s1_z_ff;
   logic        up1;

   assign up1 = ({d1_rem, 1'b0} > {1'b0, d1_side[31:17]}) ||
                (({d1_rem, 1'b0} == {1'b0, d1_side[31:17]}) && d1_quo[0]);
   assign s1_w_in = d1_side[0] ? (d1_quo + {25'd0, up1}) : {11'd0, d1_side[16:2]};
   assign s1_h_in = d1_side[0] ? {4'd0, fe_ff} : d1_side[31:17];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= d1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_h_ff <= s1_h_in;
         s1_w_ff <= s1_w_in;
         s1_z_ff <= d1_side[1];
      end
   end

   // stage 2: raise of short width
   logic        s2_valid_ff;
   logic [14:0] s2_h_ff;
   logic [25:0] s2_w_ff, s2_hf_ff;
   logic        s2_z_ff, s2_r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_h_ff  <= s1_h_ff;
         s2_w_ff  <= s1_w_ff;
         s2_hf_ff <= 26'(s1_h_ff * fe_ff);
         s2_z_ff  <= s1_z_ff;
         s2_r_ff  <= (s1_w_ff < {15'd0, fe_ff});
      end
   end

   assign ctl2.en    = adv;
   assign ctl2.valid = s2_valid_ff;

   logic        d2_valid;
   logic [25:0] d2_quo, d2_rem;
   logic [42:0] d2_side;

   tspg_div #(.NW(26), .DW(26), .SW(43)) u_div2 (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (ctl2),
      .in_num    (s2_hf_ff),
      .in_den    (s2_w_ff),
      .in_side   ({s2_h_ff, s2_w_ff, s2_z_ff, s2_r_ff}),
      .out_valid (d2_valid),
      .out_quo   (d2_quo),
      .out_rem   (d2_rem),
      .out_side  (d2_side)
   );

   // stage 3: rounded height after width raise
   logic        s3_valid_ff;
   logic [25:0] s3_h_ff, s3_w_ff, s3_h_in, s3_w_in;
   logic        s3_z_ff;
   logic        up2;

   assign up2 = ({d2_rem, 1'b0} > {1'b0, d2_side[27:2]}) ||
                (({d2_rem, 1'b0} == {1'b0, d2_side[27:2]}) && d2_quo[0]);
   assign s3_h_in = d2_side[0] ? (d2_quo + {25'd0, up2}) : {11'd0, d2_side[42:28]};
   assign s3_w_in = d2_side[0] ? {15'd0, fe_ff} : d2_side[27:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_h_ff <= s3_h_in;
         s3_w_ff <= s3_w_in;
         s3_z_ff <= d2_side[1];
      end
   end

   // stage 4: aspect check
   logic        s4_valid_ff;
   logic [18:0] s4_h_ff, s4_w_ff;
   logic        s4_err_ff;
   logic [25:0] hi4, lo4;
   logic [33:0] lim4;

   assign hi4  = (s3_h_ff > s3_w_ff) ? s3_h_ff : s3_w_ff;
   assign lo4  = (s3_h_ff > s3_w_ff) ? s3_w_ff : s3_h_ff;
   assign lim4 = 34'(lo4 * tspg_pkg::ASPECT_LIMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_h_ff   <= s3_h_ff[18:0];
         s4_w_ff   <= s3_w_ff[18:0];
         s4_err_ff <= s3_z_ff || ({8'd0, hi4} > lim4);
      end
   end

   assign ctl4.en    = adv;
   assign ctl4.valid = s4_valid_ff;

   logic        d3_valid, d4_valid;
   logic [18:0] d3_quo, d4_quo;
   logic [10:0] d3_rem, d4_rem;
   logic [37:0] d3_side;
   logic        d4_side;

   tspg_div #(.NW(19), .DW(11), .SW(38)) u_div3 (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (ctl4),
      .in_num    (s4_h_ff),
      .in_den    (fe_ff),
      .in_side   ({s4_h_ff, s4_w_ff}),
      .out_valid (d3_valid),
      .out_quo   (d3_quo),
      .out_rem   (d3_rem),
      .out_side  (d3_side)
   );

   tspg_div #(.NW(19), .DW(11), .SW(1)) u_div4 (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (ctl4),
      .in_num    (s4_w_ff),
      .in_den    (fe_ff),
      .in_side   (s4_err_ff),
      .out_valid (d4_valid),
      .out_quo   (d4_quo),
      .out_rem   (d4_rem),
      .out_side  (d4_side)
   );

   // stage 5: round sides to grid units
   logic        s5_valid_ff;
   logic [19:0] s5_qh_ff, s5_qw_ff;
   logic [18:0] s5_h_ff, s5_w_ff;
   logic        s5_err_ff;
   logic        up3, up4;

   assign up3 = ({d3_rem, 1'b0} > {1'b0, fe_ff}) ||
                (({d3_rem, 1'b0} == {1'b0, fe_ff}) && d3_quo[0]);
   assign up4 = ({d4_rem, 1'b0} > {1'b0, fe_ff}) ||
                (({d4_rem, 1'b0} == {1'b0, fe_ff}) && d4_quo[0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s5_valid_ff <= d3_valid & d4_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_qh_ff  <= {1'b0, d3_quo} + {19'd0, up3};
         s5_qw_ff  <= {1'b0, d4_quo} + {19'd0, up4};
         s5_h_ff   <= d3_side[37:19];
         s5_w_ff   <= d3_side[18:0];
         s5_err_ff <= d4_side;
      end
   end

   // stage 6: back to pixels
   logic        s6_valid_ff;
   logic [18:0] s6_hb_ff, s6_wb_ff;
   logic [18:0] s6_h_ff, s6_w_ff;
   logic        s6_err_ff;
   logic [29:0] hb6, wb6;

   assign hb6 = 30'(s5_qh_ff * fe_ff);
   assign wb6 = 30'(s5_qw_ff * fe_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (adv) begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_hb_ff  <= hb6[18:0];
         s6_wb_ff  <= wb6[18:0];
         s6_h_ff   <= s5_h_ff;
         s6_w_ff   <= s5_w_ff;
         s6_err_ff <= s5_err_ff;
      end
   end

   // stage 7: area
   logic        s7_valid_ff;
   logic [37:0] s7_area_ff;
   logic [18:0] s7_hb_ff, s7_wb_ff;
   logic [18:0] s7_h_ff, s7_w_ff;
   logic        s7_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else if (adv) begin
         s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_area_ff <= 38'(s6_hb_ff * s6_wb_ff);
         s7_hb_ff   <= s6_hb_ff;
         s7_wb_ff   <= s6_wb_ff;
         s7_h_ff    <= s6_h_ff;
         s7_w_ff    <= s6_w_ff;
         s7_err_ff  <= s6_err_ff;
      end
   end

   // stage 8: budget compare
   logic        s8_valid_ff;
   logic        s8_over_ff, s8_under_ff;
   logic [27:0] s8_a_ff;
   logic [18:0] s8_hb_ff, s8_wb_ff;
   logic [18:0] s8_h_ff, s8_w_ff;
   logic        s8_err_ff;
   logic        over8;

   assign over8 = (s7_area_ff > {10'd0, max_area_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_valid_ff <= 1'b0;
      end else if (adv) begin
         s8_valid_ff <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s8_over_ff  <= over8;
         s8_under_ff <= !over8 && (s7_area_ff < {10'd0, min_area_ff});
         s8_a_ff     <= over8 ? max_area_ff : min_area_ff;
         s8_hb_ff    <= s7_hb_ff;
         s8_wb_ff    <= s7_wb_ff;
         s8_h_ff     <= s7_h_ff;
         s8_w_ff     <= s7_w_ff;
         s8_err_ff   <= s7_err_ff;
      end
   end

   // stage 9: scaled numerators and denominators
   logic        s9_valid_ff;
   logic [46:0] s9_nh_ff, s9_nw_ff;
   logic [40:0] s9_dh_ff, s9_dw_ff;
   logic        s9_over_ff, s9_under_ff;
   logic [18:0] s9_hb_ff, s9_wb_ff;
   logic        s9_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_valid_ff <= 1'b0;
      end else if (adv) begin
         s9_valid_ff <= s8_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s9_nh_ff    <= 47'(s8_h_ff * s8_a_ff);
         s9_nw_ff    <= 47'(s8_w_ff * s8_a_ff);
         s9_dh_ff    <= 41'(ff_ff * s8_w_ff);
         s9_dw_ff    <= 41'(ff_ff * s8_h_ff);
         s9_over_ff  <= s8_over_ff;
         s9_under_ff <= s8_under_ff;
         s9_hb_ff    <= s8_hb_ff;
         s9_wb_ff    <= s8_wb_ff;
         s9_err_ff   <= s8_err_ff;
      end
   end

   assign ctl9.en    = adv;
   assign ctl9.valid = s9_valid_ff;

   logic        d5_valid, d6_valid;
   logic [46:0] d5_quo, d6_quo;
   logic [40:0] d5_rem, d6_rem;
   logic [39:0] d5_side;
   logic        d6_side;

   tspg_div #(.NW(47), .DW(41), .SW(40)) u_div5 (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (ctl9),
      .in_num    (s9_nh_ff),
      .in_den    (s9_dh_ff),
      .in_side   ({s9_hb_ff, s9_wb_ff, s9_over_ff, s9_under_ff}),
      .out_valid (d5_valid),
      .out_quo   (d5_quo),
      .out_rem   (d5_rem),
      .out_side  (d5_side)
   );

   tspg_div #(.NW(47), .DW(41), .SW(1)) u_div6 (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (ctl9),
      .in_num    (s9_nw_ff),
      .in_den    (s9_dw_ff),
      .in_side   (s9_err_ff),
      .out_valid (d6_valid),
      .out_quo   (d6_quo),
      .out_rem   (d6_rem),
      .out_side  (d6_side)
   );

   // stage 10: ceiling for the under budget case
   logic        s10_valid_ff;
   logic [35:0] s10_sh_ff, s10_sw_ff;
   logic [39:0] s10_side_ff;
   logic        s10_err_ff;
   logic        under10;

   assign under10 = d5_side[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s10_valid_ff <= 1'b0;
      end else if (adv) begin
         s10_valid_ff <= d5_valid & d6_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s10_sh_ff   <= d5_quo[35:0] + {35'd0, under10 && (d5_rem != 41'd0)};
         s10_sw_ff   <= d6_quo[35:0] + {35'd0, under10 && (d6_rem != 41'd0)};
         s10_side_ff <= d5_side;
         s10_err_ff  <= d6_side;
      end
   end

   assign ctl10.en    = adv;
   assign ctl10.valid = s10_valid_ff;

   logic        q1_valid, q2_valid;
   logic [17:0] q1_root, q2_root;
   logic        q1_inexact, q2_inexact;
   logic [39:0] q1_side;
   logic        q2_side;

   tspg_sqrt #(.NW(36), .SW(40)) u_sqrt1 (
      .clock       (clock),
      .reset       (reset),
      .in_ctl      (ctl10),
      .in_rad      (s10_sh_ff),
      .in_side     (s10_side_ff),
      .out_valid   (q1_valid),
      .out_root    (q1_root),
      .out_inexact (q1_inexact),
      .out_side    (q1_side)
   );

   tspg_sqrt #(.NW(36), .SW(1)) u_sqrt2 (
      .clock       (clock),
      .reset       (reset),
      .in_ctl      (ctl10),
      .in_rad      (s10_sw_ff),
      .in_side     (s10_err_ff),
      .out_valid   (q2_valid),
      .out_root    (q2_root),
      .out_inexact (q2_inexact),
      .out_side    (q2_side)
   );

   // stage 11: ceiling of the root for the under budget case
   logic        s11_valid_ff;
   logic [18:0] s11_kh_ff, s11_kw_ff;
   logic [18:0] s11_hb_ff, s11_wb_ff;
   logic        s11_scaled_ff, s11_err_ff;
   logic        under11;

   assign under11 = q1_side[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s11_valid_ff <= 1'b0;
      end else if (adv) begin
         s11_valid_ff <= q1_valid & q2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s11_kh_ff     <= {1'b0, q1_root} + {18'd0, under11 && q1_inexact};
         s11_kw_ff     <= {1'b0, q2_root} + {18'd0, under11 && q2_inexact};
         s11_hb_ff     <= q1_side[39:21];
         s11_wb_ff     <= q1_side[20:2];
         s11_scaled_ff <= q1_side[1] | q1_side[0];
         s11_err_ff    <= q2_side;
      end
   end

   // stage 12: final sides in pixels
   logic        s12_valid_ff;
   logic [29:0] s12_oh_ff, s12_ow_ff;
   logic        s12_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s12_valid_ff <= 1'b0;
      end else if (adv) begin
         s12_valid_ff <= s11_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s12_oh_ff  <= s11_scaled_ff ? 30'(s11_kh_ff * fe_ff) : {11'd0, s11_hb_ff};
         s12_ow_ff  <= s11_scaled_ff ? 30'(s11_kw_ff * fe_ff) : {11'd0, s11_wb_ff};
         s12_err_ff <= s11_err_ff;
      end
   end

   // output register
   logic [15:0] out_h_ff, out_w_ff;
   logic [1:0]  out_code_ff, code13;

   always_comb begin
      if (s12_err_ff) begin
         code13 = tspg_pkg::ERR_ASPECT;
      end else if ((s12_oh_ff > tspg_pkg::MAX_SIDE) || (s12_ow_ff > tspg_pkg::MAX_SIDE)) begin
         code13 = tspg_pkg::ERR_RANGE;
      end else begin
         code13 = tspg_pkg::ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= s12_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_code_ff <= code13;
         out_h_ff    <= (code13 == tspg_pkg::ERR_NONE) ? s12_oh_ff[15:0] : 16'd0;
         out_w_ff    <= (code13 == tspg_pkg::ERR_NONE) ? s12_ow_ff[15:0] : 16'd0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_w_ff, out_h_ff};
   assign rsp_tuser  = out_code_ff;

endmodule

`default_nettype wire
